// ===== src/evmbis_pkg.sv =====
`default_nettype none

package evmbis_pkg;

   // width of the section offset and instruction index counters (8 to 32)
   localparam int OFFSET_BITS = 16;
   localparam int OUT_BITS    = 16;

   // opcode values
   localparam logic [7:0] OPC_PUSH1    = 8'h60;
   localparam logic [7:0] OPC_PUSH32   = 8'h7f;
   localparam logic [7:0] OPC_DUP1     = 8'h80;
   localparam logic [7:0] OPC_DUP16    = 8'h8f;
   localparam logic [7:0] OPC_SWAP1    = 8'h90;
   localparam logic [7:0] OPC_SWAP16   = 8'h9f;
   localparam logic [7:0] OPC_INVALID  = 8'hfe;
   localparam logic [7:0] OPC_JUMPDEST = 8'h5b;

   // instruction class codes
   localparam logic [2:0] CLASS_OTHER    = 3'd0;
   localparam logic [2:0] CLASS_PUSH     = 3'd1;
   localparam logic [2:0] CLASS_DUP      = 3'd2;
   localparam logic [2:0] CLASS_SWAP     = 3'd3;
   localparam logic [2:0] CLASS_CREATEND = 3'd4;

   typedef logic [OFFSET_BITS-1:0] count_type;

   // opcode decode flags
   typedef struct packed {
      logic       is_push;
      logic       is_dup;
      logic       is_swap;
      logic       is_invalid;
      logic       is_jumpdest;
      logic [5:0] push_len;
   } decode_type;

   // one result item
   typedef struct packed {
      logic                is_opcode;
      logic [2:0]          instr_class;
      logic [7:0]          opcode_value;
      logic                in_runtime;
      logic [OUT_BITS-1:0] section_offset;
      logic [OUT_BITS-1:0] instr_index;
      logic [7:0]          imm_byte;
      logic                imm_last;
      logic                is_jumpdest;
      logic                truncated_push;
   } result_type;

   // low output bits of a counter, zero-extended when the counter is narrow
   function automatic logic [OUT_BITS-1:0] count_out(input count_type v);
      logic [31:0] wide;
      wide = 32'(v);
      return wide[OUT_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== src/evmbis_opdecode.sv =====
`default_nettype none

module evmbis_opdecode (
   input  wire logic [7:0]           code_byte,
   output evmbis_pkg::decode_type    dec
);

   // range compares on the opcode byte
   always_comb begin
      dec.is_push     = (code_byte >= evmbis_pkg::OPC_PUSH1) &&
                        (code_byte <= evmbis_pkg::OPC_PUSH32);
      dec.is_dup      = (code_byte >= evmbis_pkg::OPC_DUP1) &&
                        (code_byte <= evmbis_pkg::OPC_DUP16);
      dec.is_swap     = (code_byte >= evmbis_pkg::OPC_SWAP1) &&
                        (code_byte <= evmbis_pkg::OPC_SWAP16);
      dec.is_invalid  = (code_byte == evmbis_pkg::OPC_INVALID);
      dec.is_jumpdest = (code_byte == evmbis_pkg::OPC_JUMPDEST);
      // pushn carries n = low five bits plus one data bytes
      dec.push_len    = 6'(code_byte[4:0]) + 6'd1;
   end

endmodule

`default_nettype wire

// ===== src/evmbis_step.sv =====
`default_nettype none

module evmbis_step (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   advance,
   input  wire logic                   creation_mode,
   input  wire logic [7:0]             code_byte,
   input  wire logic                   start_of_code,
   output evmbis_pkg::result_type      result
);

   logic                  runtime_ff,  runtime_in;
   logic [5:0]            left_ff,     left_in;
   evmbis_pkg::count_type offset_ff,   offset_in;
   evmbis_pkg::count_type icount_ff,   icount_in;
   logic [7:0]            owner_ff,    owner_in;

   logic                  cur_runtime;
   logic [5:0]            cur_left;
   evmbis_pkg::count_type cur_offset;
   evmbis_pkg::count_type cur_icount;
   logic [5:0]            left_dec;
   evmbis_pkg::decode_type dec;

   evmbis_opdecode u_opdecode (
      .code_byte (code_byte),
      .dec       (dec)
   );

   // a new program start replaces the running state
   always_comb begin
      cur_runtime = start_of_code ? ~creation_mode : runtime_ff;
      cur_left    = start_of_code ? 6'd0 : left_ff;
      cur_offset  = start_of_code ? '0 : offset_ff;
      cur_icount  = start_of_code ? '0 : icount_ff;
      left_dec    = cur_left - 6'd1;
   end

   // per byte result and next state
   always_comb begin
      result                = '0;
      result.in_runtime     = cur_runtime;
      result.section_offset = evmbis_pkg::count_out(cur_offset);
      result.truncated_push = start_of_code && (left_ff != 6'd0);

      runtime_in = cur_runtime;
      left_in    = cur_left;
      offset_in  = cur_offset + evmbis_pkg::count_type'(1);
      icount_in  = cur_icount;
      owner_in   = owner_ff;

      if (cur_left != 6'd0) begin
         // immediate data byte of a push
         result.is_opcode    = 1'b0;
         result.instr_class  = evmbis_pkg::CLASS_PUSH;
         result.opcode_value = owner_ff;
         result.instr_index  =
            evmbis_pkg::count_out(cur_icount - evmbis_pkg::count_type'(1));
         result.imm_byte     = code_byte;
         result.imm_last     = (left_dec == 6'd0);
         left_in             = left_dec;
      end else begin
         // opcode byte
         result.is_opcode    = 1'b1;
         result.opcode_value = code_byte;
         result.instr_index  = evmbis_pkg::count_out(cur_icount);
         icount_in           = cur_icount + evmbis_pkg::count_type'(1);
         if (dec.is_push) begin
            result.instr_class = evmbis_pkg::CLASS_PUSH;
            left_in            = dec.push_len;
            owner_in           = code_byte;
         end else if (dec.is_dup) begin
            result.instr_class = evmbis_pkg::CLASS_DUP;
         end else if (dec.is_swap) begin
            result.instr_class = evmbis_pkg::CLASS_SWAP;
         end else if (!cur_runtime && dec.is_invalid) begin
            // end of creation section, runtime counts restart at zero
            result.instr_class = evmbis_pkg::CLASS_CREATEND;
            runtime_in         = 1'b1;
            offset_in          = '0;
            icount_in          = '0;
         end else begin
            result.instr_class = evmbis_pkg::CLASS_OTHER;
            result.is_jumpdest = dec.is_jumpdest;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         runtime_ff <= 1'b0;
         left_ff    <= 6'd0;
         offset_ff  <= '0;
         icount_ff  <= '0;
      end else if (advance) begin
         runtime_ff <= runtime_in;
         left_ff    <= left_in;
         offset_ff  <= offset_in;
         icount_ff  <= icount_in;
      end
   end

   // owning push opcode, only read while data bytes are pending
   always_ff @(posedge clock) begin
      if (advance) begin
         owner_ff <= owner_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/evm_bytecode_instruction_splitter_unit.sv =====
`default_nettype none

// Splits an EVM bytecode stream, one byte per transfer, into classified opcode
// and push-data results, one result per input byte in the same order. Each byte
// is captured in an input register, then decoded and counted by short logic and
// held in a result register, so a new byte is taken every cycle while results
// are being taken; throughput is one byte per clock, and rsp_valid rises once
// the byte has passed both the input and the result register. Offsets and
// instruction indices count per section and wrap at the counter width. Assert
// req_start_of_code on the first byte of each program; it also flags push data
// cut off by the new start. Write csr_creation_mode_at_start only while idle.
module evm_bytecode_instruction_splitter_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   // configuration
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_creation_mode_at_start,
   // byte input
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_code_byte,
   input  wire logic        req_start_of_code,
   // results
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_is_opcode,
   output logic [2:0]       rsp_instr_class,
   output logic [7:0]       rsp_opcode_value,
   output logic             rsp_in_runtime,
   output logic [15:0]      rsp_section_offset,
   output logic [15:0]      rsp_instr_index,
   output logic [7:0]       rsp_imm_byte,
   output logic             rsp_imm_last,
   output logic             rsp_is_jumpdest,
   output logic             rsp_truncated_push
);

   logic                   mode_ff;
   logic                   in_valid_ff;
   logic [7:0]             in_byte_ff;
   logic                   in_start_ff;
   logic                   out_valid_ff;
   evmbis_pkg::result_type out_ff;
   evmbis_pkg::result_type step_result;
   logic                   advance;

   // handshake control
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;
   assign rsp_valid = out_valid_ff;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else if (csr_valid) begin
         mode_ff <= csr_creation_mode_at_start;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff  <= req_code_byte;
         in_start_ff <= req_start_of_code;
      end
   end

   evmbis_step u_step (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .creation_mode (mode_ff),
      .code_byte     (in_byte_ff),
      .start_of_code (in_start_ff),
      .result        (step_result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= step_result;
      end
   end

   // result fields
   assign rsp_is_opcode      = out_ff.is_opcode;
   assign rsp_instr_class    = out_ff.instr_class;
   assign rsp_opcode_value   = out_ff.opcode_value;
   assign rsp_in_runtime     = out_ff.in_runtime;
   assign rsp_section_offset = out_ff.section_offset;
   assign rsp_instr_index    = out_ff.instr_index;
   assign rsp_imm_byte       = out_ff.imm_byte;
   assign rsp_imm_last       = out_ff.imm_last;
   assign rsp_is_jumpdest    = out_ff.is_jumpdest;
   assign rsp_truncated_push = out_ff.truncated_push;

endmodule

`default_nettype wire
